// ===== rtl/core/afbd_pkg.sv =====
// ----------------------------------------------------------------------------
// afbd_pkg
// Shared types and constants of the aspect-fit bilinear downscaler.
// ----------------------------------------------------------------------------
package afbd_pkg;

   localparam int DEF_MAX_LINE_PIXELS    = 8192;
   localparam int DEF_STEP_FRACTION_BITS = 16;

   // sizes and counters, wide enough to hold the largest line length itself
   localparam int SIZE_W      = 15;
   localparam int CFG_W       = 14;
   localparam int CSR_IDX_W   = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_WIDTH  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_HEIGHT = CSR_IDX_W'(3);

   typedef enum logic [3:0] {
      FIT_START,
      FIT_MUL,
      FIT_CMP,
      FIT_SZ_GO,
      FIT_SZ_WAIT,
      FIT_X_GO,
      FIT_X_WAIT,
      FIT_Y_GO,
      FIT_Y_WAIT,
      FIT_DONE
   } fit_state_type;

   // frame geometry handed from the fit sequencer to the front end
   typedef struct packed {
      logic              valid;
      logic              bypass;
      logic [SIZE_W-1:0] src_w;
      logic [SIZE_W-1:0] src_h;
      logic [SIZE_W-1:0] fit_w;
      logic [SIZE_W-1:0] fit_h;
   } fit_type;

   // one queued word: four neighbours, weights and output position
   typedef struct packed {
      logic [31:0] p00;
      logic [31:0] p10;
      logic [31:0] p01;
      logic [31:0] p11;
      logic [7:0]  wx;
      logic [7:0]  wy;
      logic        bypass;
      logic [12:0] col;
      logic [12:0] row;
      logic        last_row;
      logic        last_frame;
   } word_type;

endpackage

// ===== rtl/core/afbd_ifs.sv =====
// ----------------------------------------------------------------------------
// afbd_ifs
// Channel interfaces: pixel request, result response, register write.
// ----------------------------------------------------------------------------
interface afbd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_bgra;
   modport source (output valid, output pixel_bgra, input ready);
   modport sink   (input valid, input pixel_bgra, output ready);
endinterface

interface afbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel_bgra;
   logic [12:0] out_col;
   logic [12:0] out_row;
   logic        last_in_row;
   logic        last_in_frame;
   modport source (output valid, output out_pixel_bgra, output out_col, output out_row,
                   output last_in_row, output last_in_frame, input ready);
   modport sink   (input valid, input out_pixel_bgra, input out_col, input out_row,
                   input last_in_row, input last_in_frame, output ready);
endinterface

interface afbd_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [13:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/afbd_div.sv =====
// ----------------------------------------------------------------------------
// afbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afbd_div import afbd_pkg::*; #(
   parameter int DIV_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  num,
   input  logic [SIZE_W-1:0] den,
   output logic              done,
   output logic [DIV_W-1:0]  quot
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         rem_in  = ge ? SIZE_W'(trial - {1'b0, den_ff}) : trial[SIZE_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== rtl/core/afbd_fit.sv =====
// ----------------------------------------------------------------------------
// afbd_fit
// Register file and aspect-fit sequencer: fitted sizes and 15.16-style steps.
// ----------------------------------------------------------------------------
module afbd_fit import afbd_pkg::*; #(
   parameter int MAX_LINE_PIXELS    = DEF_MAX_LINE_PIXELS,
   parameter int STEP_FRACTION_BITS = DEF_STEP_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [CSR_IDX_W-1:0]                 wr_index,
   input  logic [CFG_W-1:0]                     wr_data,
   output logic                                 restart,
   output fit_type                              fit,
   output logic [SIZE_W+STEP_FRACTION_BITS-1:0] x_step,
   output logic [SIZE_W+STEP_FRACTION_BITS-1:0] y_step
);

   localparam int POS_W = SIZE_W + STEP_FRACTION_BITS;
   localparam int DIV_W = (POS_W > 2 * SIZE_W) ? POS_W : 2 * SIZE_W;
   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_LINE_PIXELS);

   logic [CFG_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic             hit_reg;

   fit_state_type     state_ff, state_in;
   logic [SIZE_W-1:0] sw, sh, tw, th;
   logic [2*SIZE_W-1:0] prod_a_ff, prod_b_ff;
   logic              wide_ff, wide_in;
   logic              bypass_ff, bypass_in;
   logic [SIZE_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [POS_W-1:0]  xs_ff, xs_in, ys_ff, ys_in;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_num, div_quot;
   logic [SIZE_W-1:0] div_den, q_floor;

   always_comb begin
      hit_reg = wr_en && (wr_index == REG_SOURCE_WIDTH || wr_index == REG_SOURCE_HEIGHT ||
                          wr_index == REG_TARGET_WIDTH || wr_index == REG_TARGET_HEIGHT);
   end
   assign restart = hit_reg;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= CFG_W'(1);
         src_h_ff <= CFG_W'(1);
         tgt_w_ff <= '0;
         tgt_h_ff <= '0;
      end else if (wr_en) begin
         unique case (wr_index)
            REG_SOURCE_WIDTH:  src_w_ff <= wr_data;
            REG_SOURCE_HEIGHT: src_h_ff <= wr_data;
            REG_TARGET_WIDTH:  tgt_w_ff <= wr_data;
            REG_TARGET_HEIGHT: tgt_h_ff <= wr_data;
            default: ;
         endcase
      end
   end

   // zero source counts as one, everything saturates at the line length
   always_comb begin
      sw = (src_w_ff == '0) ? SIZE_W'(1) : SIZE_W'(src_w_ff);
      sh = (src_h_ff == '0) ? SIZE_W'(1) : SIZE_W'(src_h_ff);
      tw = SIZE_W'(tgt_w_ff);
      th = SIZE_W'(tgt_h_ff);
      if (sw > MAX_SIZE) sw = MAX_SIZE;
      if (sh > MAX_SIZE) sh = MAX_SIZE;
      if (tw > MAX_SIZE) tw = MAX_SIZE;
      if (th > MAX_SIZE) th = MAX_SIZE;
   end

   always_comb begin
      q_floor   = (div_quot == '0) ? SIZE_W'(1) : div_quot[SIZE_W-1:0];
      state_in  = state_ff;
      wide_in   = wide_ff;
      bypass_in = bypass_ff;
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      xs_in     = xs_ff;
      ys_in     = ys_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = SIZE_W'(1);
      unique case (state_ff)
         FIT_START: begin
            bypass_in = (tw == '0) || (th == '0) || ((sw <= tw) && (sh <= th));
            fw_in     = sw;
            fh_in     = sh;
            xs_in     = '0;
            ys_in     = '0;
            state_in  = bypass_in ? FIT_DONE : FIT_MUL;
         end
         FIT_MUL: state_in = FIT_CMP;
         FIT_CMP: begin
            wide_in = (prod_a_ff > prod_b_ff);
            if (wide_in) fw_in = tw;
            else         fh_in = th;
            state_in = FIT_SZ_GO;
         end
         FIT_SZ_GO: begin
            div_start = 1'b1;
            div_num   = wide_ff ? DIV_W'(prod_b_ff) : DIV_W'(prod_a_ff);
            div_den   = wide_ff ? sw : sh;
            state_in  = FIT_SZ_WAIT;
         end
         FIT_SZ_WAIT: begin
            if (div_done) begin
               if (wide_ff) fh_in = q_floor;
               else         fw_in = q_floor;
               state_in = FIT_X_GO;
            end
         end
         FIT_X_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'({sw, {STEP_FRACTION_BITS{1'b0}}});
            div_den   = fw_ff;
            state_in  = FIT_X_WAIT;
         end
         FIT_X_WAIT: begin
            if (div_done) begin
               xs_in    = div_quot[POS_W-1:0];
               state_in = FIT_Y_GO;
            end
         end
         FIT_Y_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'({sh, {STEP_FRACTION_BITS{1'b0}}});
            div_den   = fh_ff;
            state_in  = FIT_Y_WAIT;
         end
         FIT_Y_WAIT: begin
            if (div_done) begin
               ys_in    = div_quot[POS_W-1:0];
               state_in = FIT_DONE;
            end
         end
         FIT_DONE: ;
         default: state_in = FIT_START;
      endcase
      if (hit_reg) state_in = FIT_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIT_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= sw * th;
      prod_b_ff <= tw * sh;
      wide_ff   <= wide_in;
      bypass_ff <= bypass_in;
      fw_ff     <= fw_in;
      fh_ff     <= fh_in;
      xs_ff     <= xs_in;
      ys_ff     <= ys_in;
   end

   afbd_div #(.DIV_W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      fit.valid  = (state_ff == FIT_DONE);
      fit.bypass = bypass_ff;
      fit.src_w  = sw;
      fit.src_h  = sh;
      fit.fit_w  = fw_ff;
      fit.fit_h  = fh_ff;
   end
   assign x_step = xs_ff;
   assign y_step = ys_ff;

endmodule

// ===== rtl/core/afbd_front.sv =====
// ----------------------------------------------------------------------------
// afbd_front
// Source raster tracking, line store, neighbour capture and output decision.
// ----------------------------------------------------------------------------
module afbd_front import afbd_pkg::*; #(
   parameter int MAX_LINE_PIXELS    = DEF_MAX_LINE_PIXELS,
   parameter int STEP_FRACTION_BITS = DEF_STEP_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [31:0]                          pixel,
   input  logic                                 restart,
   input  fit_type                              fit,
   input  logic [SIZE_W+STEP_FRACTION_BITS-1:0] x_step,
   input  logic [SIZE_W+STEP_FRACTION_BITS-1:0] y_step,
   output logic                                 push,
   output word_type                             word
);

   localparam int POS_W  = SIZE_W + STEP_FRACTION_BITS;
   localparam int ADDR_W = $clog2(MAX_LINE_PIXELS);

   logic [31:0]       row_store [MAX_LINE_PIXELS];
   logic [31:0]       above_ff;
   logic [31:0]       left_ff, upleft_ff;
   logic [SIZE_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [SIZE_W-1:0] dcol_ff, dcol_in, drow_ff, drow_in;
   logic [POS_W-1:0]  xpos_ff, xpos_in, ypos_ff, ypos_in;
   logic              bypass_ff, bypass_in;

   logic              frame_start, byp, active, hit, end_row, col_end, row_end;
   logic [SIZE_W-1:0] dcol, drow, x0, y0, x1, y1;
   logic [POS_W-1:0]  xpos, ypos;
   logic [31:0]       p00, p10, p01, p11;

   always_comb begin
      frame_start = (col_ff == '0) && (row_ff == '0);
      dcol = frame_start ? '0 : dcol_ff;
      drow = frame_start ? '0 : drow_ff;
      xpos = frame_start ? '0 : xpos_ff;
      ypos = frame_start ? '0 : ypos_ff;
      byp  = frame_start ? fit.bypass : bypass_ff;

      x0 = xpos[POS_W-1:STEP_FRACTION_BITS];
      y0 = ypos[POS_W-1:STEP_FRACTION_BITS];
      x1 = ((x0 + SIZE_W'(1)) < fit.src_w) ? x0 + SIZE_W'(1) : fit.src_w - SIZE_W'(1);
      y1 = ((y0 + SIZE_W'(1)) < fit.src_h) ? y0 + SIZE_W'(1) : fit.src_h - SIZE_W'(1);

      active  = (drow < fit.fit_h) && (dcol < fit.fit_w);
      hit     = !byp && active && (row_ff == y1) && (col_ff == x1);
      end_row = (dcol + SIZE_W'(1)) >= fit.fit_w;
      col_end = (col_ff + SIZE_W'(1)) >= fit.src_w;
      row_end = (row_ff + SIZE_W'(1)) >= fit.src_h;

      // a neighbour that coincides falls back on the current pixel or row
      p00 = upleft_ff;
      p10 = above_ff;
      p01 = left_ff;
      p11 = pixel;
      if (x0 == x1) begin
         p01 = p11;
         p00 = p10;
      end
      if (y0 == y1) begin
         p00 = p01;
         p10 = p11;
      end

      push            = accept && (byp || hit);
      word.p00        = p00;
      word.p10        = p10;
      word.p01        = p01;
      word.p11        = p11;
      word.wx         = xpos[STEP_FRACTION_BITS-1 -: 8];
      word.wy         = ypos[STEP_FRACTION_BITS-1 -: 8];
      word.bypass     = byp;
      word.col        = byp ? col_ff[12:0] : dcol[12:0];
      word.row        = byp ? row_ff[12:0] : drow[12:0];
      word.last_row   = byp ? col_end : end_row;
      word.last_frame = byp ? (col_end && row_end)
                            : (end_row && ((drow + SIZE_W'(1)) >= fit.fit_h));

      col_in    = col_ff;
      row_in    = row_ff;
      dcol_in   = dcol_ff;
      drow_in   = drow_ff;
      xpos_in   = xpos_ff;
      ypos_in   = ypos_ff;
      bypass_in = bypass_ff;
      if (accept) begin
         bypass_in = byp;
         dcol_in   = dcol;
         drow_in   = drow;
         xpos_in   = xpos;
         ypos_in   = ypos;
         if (hit) begin
            if (end_row) begin
               dcol_in = '0;
               xpos_in = '0;
               drow_in = drow + SIZE_W'(1);
               ypos_in = ypos + y_step;
            end else begin
               dcol_in = dcol + SIZE_W'(1);
               xpos_in = xpos + x_step;
            end
         end
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + SIZE_W'(1);
         end else begin
            col_in = col_ff + SIZE_W'(1);
         end
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         dcol_ff   <= '0;
         drow_ff   <= '0;
         xpos_ff   <= '0;
         ypos_ff   <= '0;
         bypass_ff <= 1'b0;
         left_ff   <= '0;
         upleft_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         dcol_ff   <= dcol_in;
         drow_ff   <= drow_in;
         xpos_ff   <= xpos_in;
         ypos_ff   <= ypos_in;
         bypass_ff <= bypass_in;
         if (accept) begin
            left_ff   <= pixel;
            upleft_ff <= above_ff;
         end
      end
   end

   // line store: read ahead at the next column, new data wins on a collision
   always_ff @(posedge clock) begin
      if (accept) begin
         row_store[col_ff[ADDR_W-1:0]] <= pixel;
      end
      if (accept && (col_ff[ADDR_W-1:0] == col_in[ADDR_W-1:0])) begin
         above_ff <= pixel;
      end else begin
         above_ff <= row_store[col_in[ADDR_W-1:0]];
      end
   end

endmodule

// ===== rtl/core/afbd_queue.sv =====
// ----------------------------------------------------------------------------
// afbd_queue
// Short word queue between front end and blend pipeline.
// ----------------------------------------------------------------------------
module afbd_queue import afbd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   input  logic     pop,
   output word_type head,
   output logic     empty,
   output logic     full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   word_type         slots [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + PTR_W'(1);
         if (do_pop)  rd_ff <= rd_ff + PTR_W'(1);
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + CNT_W'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots[wr_ff] <= push_word;
   end

endmodule

// ===== rtl/core/afbd_back.sv =====
// ----------------------------------------------------------------------------
// afbd_back
// Two-stage bilinear blend: horizontal pass, then vertical pass into the output register.
// ----------------------------------------------------------------------------
module afbd_back import afbd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  word_type       head,
   input  logic           empty,
   output logic           pop,
   afbd_rsp_if.source     rsp
);

   logic        s1_valid_ff, out_valid_ff;
   logic        en1, en2;
   logic [15:0] top_in [4];
   logic [15:0] bot_in [4];
   logic [15:0] top_ff [4];
   logic [15:0] bot_ff [4];
   logic [7:0]  wy_ff;
   word_type    s1_ff;
   logic [31:0] blend;
   logic [23:0] acc [4];
   logic [8:0]  iwx, iwy;

   assign en2 = !out_valid_ff || rsp.ready;
   assign en1 = !s1_valid_ff || en2;
   assign pop = en1 && !empty;

   // full weight sum is 65536, so the shifted result never exceeds 255
   always_comb begin
      iwx = 9'd256 - {1'b0, head.wx};
      iwy = 9'd256 - {1'b0, wy_ff};
      for (int c = 0; c < 4; c++) begin
         top_in[c] = 16'(head.p00[c*8 +: 8]) * 16'(iwx) + 16'(head.p10[c*8 +: 8]) * 16'(head.wx);
         bot_in[c] = 16'(head.p01[c*8 +: 8]) * 16'(iwx) + 16'(head.p11[c*8 +: 8]) * 16'(head.wx);
         acc[c]    = 24'(top_ff[c]) * 24'(iwy) + 24'(bot_ff[c]) * 24'(wy_ff);
         blend[c*8 +: 8] = acc[c][23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= !empty;
         if (en2) out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff  <= head;
         wy_ff  <= head.wy;
         top_ff <= top_in;
         bot_ff <= bot_in;
      end
      if (en2) begin
         rsp.out_pixel_bgra <= s1_ff.bypass ? s1_ff.p11 : blend;
         rsp.out_col        <= s1_ff.col;
         rsp.out_row        <= s1_ff.row;
         rsp.last_in_row    <= s1_ff.last_row;
         rsp.last_in_frame  <= s1_ff.last_frame;
      end
   end

   assign rsp.valid = out_valid_ff;

endmodule

// ===== rtl/core/aspect_fit_bilinear_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// aspect_fit_bilinear_downscaler_top
// A result word passes the queue slot, the blend stage register and the output
// register after the pixel that completes it. Throughput: one pixel per cycle
// while the fit is settled and the queue has room. After reset and after every
// write to a size register the fit sequencer recomputes the fit, on one serial
// divider shared by up to three divisions; no pixel is taken meanwhile.
// Synchronous active-high reset; the line store has no clearing pass.
// ----------------------------------------------------------------------------
module aspect_fit_bilinear_downscaler_top import afbd_pkg::*; #(
   parameter int MAX_LINE_PIXELS    = DEF_MAX_LINE_PIXELS,
   parameter int STEP_FRACTION_BITS = DEF_STEP_FRACTION_BITS
) (
   input  logic       clock,
   input  logic       reset,
   afbd_req_if.sink   req_chan,
   afbd_rsp_if.source rsp_chan,
   afbd_csr_if.sink   csr_chan
);

   localparam int POS_W = SIZE_W + STEP_FRACTION_BITS;

   fit_type          fit;
   logic [POS_W-1:0] x_step, y_step;
   logic             restart, csr_wr, accept, push, pop, q_empty, q_full;
   word_type         push_word, head;

   // register writes always taken; user must write only when idle (unenforced)
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid && csr_chan.ready;

   // pixels flow once the fit is settled and the queue has room
   assign req_chan.ready = fit.valid && !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   afbd_fit #(
      .MAX_LINE_PIXELS    (MAX_LINE_PIXELS),
      .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
   ) u_fit (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .restart  (restart),
      .fit      (fit),
      .x_step   (x_step),
      .y_step   (y_step)
   );

   // front: raster position, previous-row store, 2x2 capture, emit decision
   afbd_front #(
      .MAX_LINE_PIXELS    (MAX_LINE_PIXELS),
      .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pixel   (req_chan.pixel_bgra),
      .restart (restart),
      .fit     (fit),
      .x_step  (x_step),
      .y_step  (y_step),
      .push    (push),
      .word    (push_word)
   );

   afbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: blend pipeline with its own output register
   afbd_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (q_empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

   // no pixel is taken while the fit is being recomputed
   a_ready_needs_fit: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> fit.valid)
      else $error("pixel taken before fit settled");

   // a valid write to a size register restarts the fit
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && restart) |=> !req_chan.ready)
      else $error("fit not restarted after register write");

   // the queue is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("queue overflow");

   // a frame always ends at the end of a row
   a_frame_ends_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_in_frame) |-> rsp_chan.last_in_row)
      else $error("frame end off a row end");

endmodule
